@@ hdl/tnf_pkg.sv @@
// Package for the Tustin notch filter: widths, register map, reset values
// and the shared structs. No dependencies; used by every file in hdl/.
package tnf_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int COEF_W      = 32;
	localparam int OUT_W       = 16;
	localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	// signed operand width for a1-a2 and a1+a2
	localparam int OPND_W      = ((SAMPLE_BITS > 15) ? SAMPLE_BITS : 15) + 4;
	localparam int PROD_W      = COEF_W + 1 + OPND_W;
	localparam int ACC_W       = PROD_W + 2;
	// quotient bits kept before saturation to 16 bits
	localparam int QUO_W       = OUT_W + 1;
	localparam int DSH_W       = COEF_W + QUO_W - 1;
	localparam int CNT_W       = $clog2(QUO_W);
	localparam int ADDR_W      = 4;
	localparam int APB_W       = 32;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [COEF_W-1:0] RST_FOUR_F_SQUARED = 32'd177777778;
	localparam logic [COEF_W-1:0] RST_FOUR_F_WN      = 32'd255683754;
	localparam logic [COEF_W-1:0] RST_WN_SQUARED     = 32'd91932444;
	localparam logic [COEF_W-1:0] RST_DIVIDER        = 32'd525393975;

	typedef enum logic [1:0] {
		REG_FOUR_F_SQUARED,
		REG_FOUR_F_WN,
		REG_WN_SQUARED,
		REG_DIVIDER
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] four_f_squared;
		logic [COEF_W-1:0] four_f_wn;
		logic [COEF_W-1:0] wn_squared;
		logic [COEF_W-1:0] divider;
	} cfg_t;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

endpackage

@@ hdl/tnf_regs.sv @@
// APB-style register file for the notch filter coefficients and divider.
// Depends on tnf_pkg.
module tnf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tnf_pkg::ADDR_W-1:0]   paddr,
	input  logic [tnf_pkg::APB_W-1:0]    pwdata,
	output logic [tnf_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	output tnf_pkg::cfg_t                cfg
);

	tnf_pkg::cfg_t    cfg_q;
	tnf_pkg::reg_idx_t idx;
	logic             wr;

	assign pready = 1'b1;
	assign idx    = tnf_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_f_squared <= tnf_pkg::RST_FOUR_F_SQUARED;
			cfg_q.four_f_wn      <= tnf_pkg::RST_FOUR_F_WN;
			cfg_q.wn_squared     <= tnf_pkg::RST_WN_SQUARED;
			cfg_q.divider        <= tnf_pkg::RST_DIVIDER;
		end else if (wr) begin
			unique case (idx)
				tnf_pkg::REG_FOUR_F_SQUARED: cfg_q.four_f_squared <= pwdata;
				tnf_pkg::REG_FOUR_F_WN:      cfg_q.four_f_wn      <= pwdata;
				tnf_pkg::REG_WN_SQUARED:     cfg_q.wn_squared     <= pwdata;
				tnf_pkg::REG_DIVIDER:        cfg_q.divider        <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tnf_pkg::REG_FOUR_F_SQUARED: prdata = cfg_q.four_f_squared;
			tnf_pkg::REG_FOUR_F_WN:      prdata = cfg_q.four_f_wn;
			tnf_pkg::REG_WN_SQUARED:     prdata = cfg_q.wn_squared;
			tnf_pkg::REG_DIVIDER:        prdata = cfg_q.divider;
		endcase
	end

endmodule

@@ hdl/tnf_mac.sv @@
// Shared multiply-accumulate unit: one registered 33xOPND_W signed product
// per cycle while ctl.mul_en is high, summed into the numerator accumulator. Depends on tnf_pkg.
module tnf_mac (
	input  logic                               clk,
	input  tnf_pkg::mac_ctl_t                  ctl,
	input  logic [tnf_pkg::COEF_W-1:0]         coef,
	input  logic signed [tnf_pkg::OPND_W-1:0]  opnd,
	output logic signed [tnf_pkg::ACC_W-1:0]   acc
);

	logic signed [tnf_pkg::PROD_W-1:0] prod_s1;
	logic signed [tnf_pkg::ACC_W-1:0]  acc_q;

	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= $signed({1'b0, coef}) * opnd;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + tnf_pkg::ACC_W'(prod_s1);
		end
	end

endmodule

@@ hdl/tnf_div.sv @@
// Restoring divider: signed numerator by unsigned divider, truncating toward
// zero, saturated to 16 bits; one quotient bit per cycle. Depends on tnf_pkg.
module tnf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [tnf_pkg::ACC_W-1:0]  num,
	input  logic [tnf_pkg::COEF_W-1:0]        div,
	output logic                              done,
	output logic signed [tnf_pkg::OUT_W-1:0]  result
);

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_CHK,
		DV_RUN,
		DV_FIX,
		DV_DONE
	} dv_state_t;

	dv_state_t                         state_q;
	logic                              neg_q;
	logic [tnf_pkg::ACC_W-1:0]         mag_q;
	logic [tnf_pkg::DSH_W-1:0]         dsh_q;
	logic [tnf_pkg::QUO_W-1:0]         quo_q;
	logic [tnf_pkg::CNT_W-1:0]         cnt_q;
	logic signed [tnf_pkg::OUT_W-1:0]  res_q;

	logic [tnf_pkg::ACC_W-1:0] num_u;
	logic [tnf_pkg::ACC_W-1:0] mag_in;
	logic [tnf_pkg::ACC_W-1:0] dsh_ext;
	logic [tnf_pkg::ACC_W-1:0] lim_ext;
	logic                      ge;

	assign num_u   = num;
	assign mag_in  = num_u[tnf_pkg::ACC_W-1] ? (~num_u + tnf_pkg::ACC_W'(1)) : num_u;
	assign dsh_ext = tnf_pkg::ACC_W'(dsh_q);
	assign lim_ext = tnf_pkg::ACC_W'({dsh_q, 1'b0});
	assign ge      = (mag_q >= dsh_ext);
	assign done    = (state_q == DV_DONE);
	assign result  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			dsh_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						neg_q   <= num_u[tnf_pkg::ACC_W-1];
						mag_q   <= mag_in;
						dsh_q   <= {div, {(tnf_pkg::QUO_W-1){1'b0}}};
						quo_q   <= '0;
						state_q <= DV_CHK;
					end
				end
				DV_CHK: begin
					priority if (mag_q == '0) begin
						res_q   <= '0;
						state_q <= DV_DONE;
					end else if (mag_q >= lim_ext) begin
						// quotient beyond 17 bits, or divide by zero
						res_q   <= neg_q ? tnf_pkg::OUT_MIN : tnf_pkg::OUT_MAX;
						state_q <= DV_DONE;
					end else begin
						cnt_q   <= tnf_pkg::CNT_W'(tnf_pkg::QUO_W - 1);
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (ge) begin
						mag_q <= mag_q - dsh_ext;
					end
					quo_q <= {quo_q[tnf_pkg::QUO_W-2:0], ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - tnf_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					if (neg_q) begin
						res_q <= (quo_q > {1'b0, tnf_pkg::OUT_MIN})
							? tnf_pkg::OUT_MIN : -$signed(quo_q[tnf_pkg::OUT_W-1:0]);
					end else begin
						res_q <= (quo_q > tnf_pkg::QUO_W'(tnf_pkg::OUT_MAX))
							? tnf_pkg::OUT_MAX : $signed(quo_q[tnf_pkg::OUT_W-1:0]);
					end
					state_q <= DV_DONE;
				end
				DV_DONE: begin
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/tustin_notch_filter.sv @@
// Tustin notch filter, top level: sequencer, sample/output history, output
// register. Depends on tnf_pkg, tnf_regs, tnf_mac, tnf_div.
// Each accepted item takes multiply-accumulate steps in the shared
// multiplier, a divider check, up to 17 restoring divide steps, a fix-up
// and the output load; the divide steps and fix-up are skipped when the
// quotient saturates or the numerator is zero. s_tready is low while busy.
// Reset (arst_n low, asynchronous): history cleared, registers at defaults.
module tustin_notch_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tnf_pkg::IN_TDATA_W-1:0]       s_tdata,   // [9:0] sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tnf_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [15:0] filtered
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tnf_pkg::ADDR_W-1:0]           paddr,
	input  logic [tnf_pkg::APB_W-1:0]            pwdata,
	output logic [tnf_pkg::APB_W-1:0]            prdata,
	output logic                                 pready
);

	localparam int SB = tnf_pkg::SAMPLE_BITS;
	localparam int OW = tnf_pkg::OPND_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                            state_q;
	logic [1:0]                        step_q;
	logic [SB-1:0]                     in_prev_q;
	logic [SB-1:0]                     in_old_q;
	logic signed [tnf_pkg::OUT_W-1:0]  out_prev_q;
	logic signed [tnf_pkg::OUT_W-1:0]  out_old_q;
	logic signed [OW-1:0]              diff_q;
	logic signed [OW-1:0]              sum_q;
	logic signed [tnf_pkg::OUT_W-1:0]  res_q;
	logic signed [tnf_pkg::OUT_W-1:0]  m_tdata_q;
	logic                              m_tvalid_q;

	tnf_pkg::cfg_t                     cfg;
	tnf_pkg::mac_ctl_t                 mac_ctl;
	logic [tnf_pkg::COEF_W-1:0]        coef;
	logic signed [OW-1:0]              opnd;
	logic signed [tnf_pkg::ACC_W-1:0]  acc;
	logic                              div_start;
	logic                              div_done;
	logic signed [tnf_pkg::OUT_W-1:0]  div_res;

	logic                              accept;
	logic                              out_load;
	logic signed [OW-1:0]              u0_x;
	logic signed [OW-1:0]              u1_x;
	logic signed [OW-1:0]              u2_x;
	logic signed [OW-1:0]              y1_x;
	logic signed [OW-1:0]              y2_x;
	logic signed [OW-1:0]              a1;
	logic signed [OW-1:0]              a2;

	tnf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tnf_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.coef (coef),
		.opnd (opnd),
		.acc  (acc)
	);

	tnf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc),
		.div    (cfg.divider),
		.done   (div_done),
		.result (div_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tnf_pkg::OUT_TDATA_W'(m_tdata_q);

	assign u0_x = $signed(OW'(s_tdata[SB-1:0]));
	assign u1_x = $signed(OW'(in_prev_q));
	assign u2_x = $signed(OW'(in_old_q));
	assign y1_x = {{(OW-tnf_pkg::OUT_W){out_prev_q[tnf_pkg::OUT_W-1]}}, out_prev_q};
	assign y2_x = {{(OW-tnf_pkg::OUT_W){out_old_q[tnf_pkg::OUT_W-1]}}, out_old_q};
	assign a1   = u0_x + u2_x - y2_x;
	assign a2   = (u1_x <<< 1) - (y1_x <<< 1);

	assign mac_ctl.clr    = accept;
	assign mac_ctl.mul_en = (state_q == ST_MAC) && (step_q != 2'd3);
	assign mac_ctl.acc_en = (state_q == ST_MAC) && (step_q != 2'd0);
	// accumulator holds the full numerator once the sequencer reaches ST_DIV
	assign div_start      = (state_q == ST_DIV);

	always_comb begin
		unique case (step_q)
			2'd0: begin
				coef = cfg.four_f_squared;
				opnd = diff_q;
			end
			2'd1: begin
				coef = cfg.four_f_wn;
				opnd = y2_x;
			end
			2'd2: begin
				coef = cfg.wn_squared;
				opnd = sum_q;
			end
			2'd3: begin
				coef = cfg.wn_squared;
				opnd = sum_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			in_prev_q  <= '0;
			in_old_q   <= '0;
			out_prev_q <= '0;
			out_old_q  <= '0;
			diff_q     <= '0;
			sum_q      <= '0;
			res_q      <= '0;
			m_tdata_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						diff_q    <= a1 - a2;
						sum_q     <= a1 + a2;
						in_old_q  <= in_prev_q;
						in_prev_q <= s_tdata[SB-1:0];
						step_q    <= '0;
						state_q   <= ST_MAC;
					end
				end
				ST_MAC: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q   <= div_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata_q  <= res_q;
						out_old_q  <= out_prev_q;
						out_prev_q <= res_q;
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_history_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && (out_prev_q == $signed(m_tdata))))
		else $error("output history differs from presented item");

	a_mac_idle_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (!mac_ctl.acc_en && !mac_ctl.clr))
		else $error("accumulator disturbed during divide");

endmodule
